// ===== design/assert_macros.svh =====
// Assertion macros for the grid binner
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("never failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== design/hgeb_pkg.sv =====
// ----------------------------------------------------------------------------
// hgeb_pkg
// Shared constants and types of the height grid binner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package hgeb_pkg;
  localparam int GRID_SIDE_DEF = 512;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // register byte addresses
  localparam logic [3:0] ADDR_CELL_LEN = 4'd0;
  localparam logic [3:0] ADDR_HALF     = 4'd4;
  localparam logic [3:0] ADDR_Z_BOUND  = 4'd8;
  localparam logic [3:0] ADDR_ALPHA    = 4'd12;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // capture input beat
    logic div_start; // start divider
    logic div_sel;   // 0: x, 1: y, (level uses sel_lvl)
    logic sel_lvl;   // divide for level
    logic col_save;  // save quotient as column
    logic row_save;  // save quotient as row
    logic mem_rd;    // issue memory read
    logic mem_wr;    // write EMA result, update min/max
    logic out_load;  // load output register
    logic clr_step;  // clearing pass write
  } hgeb_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic div_done;
    logic is_read;
    logic pt_ok;     // point within map and bound
    logic cell_ok;   // binned indices within grid
    logic idx_ok;    // read index inside grid
    logic range_ok;  // max > min
    logic num_pos;   // h > min
    logic clr_last;
  } hgeb_sts_t;
endpackage

// ===== design/hgeb_div.sv =====
// ----------------------------------------------------------------------------
// hgeb_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module hgeb_div import hgeb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [23:0] dividend,
  input  logic [16:0] divisor,
  output logic        done,
  output logic [23:0] quot
);
  logic [23:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [16:0] d_r, d_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [17:0] trial;

  // one shift-subtract step
  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r, q_r[23]} - {1'b0, d_r};
    if (start) begin
      q_nxt = dividend; rem_nxt = '0; d_nxt = divisor;
      cnt_nxt = 5'd0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[17]) begin
        rem_nxt = trial[16:0];
        q_nxt = {q_r[22:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[15:0], q_r[23]};
        q_nxt = {q_r[22:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd23) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

// ===== design/hgeb_datapath.sv =====
// ----------------------------------------------------------------------------
// hgeb_datapath
// Registers, binning, grid memory, EMA update, min/max and level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module hgeb_datapath import hgeb_pkg::*; #(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  hgeb_cmd_t   cmd,
  output hgeb_sts_t   sts,
  input  logic [66:0] in_beat,
  input  logic [9:0]  cell_len,
  input  logic [8:0]  half_cells,
  input  logic [13:0] z_bound,
  input  logic [3:0]  alpha_shift,
  output logic [24:0] out_beat
);
  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int AW = $clog2(CELLS);
  localparam int HALF_LIM = GRID_SIDE / 2;

  logic              cmd_r;
  logic signed [15:0] x_r, y_r, z_r;
  logic [17:0]       idx_in_r;
  logic [8:0]        half;
  logic [9:0]        side;
  logic [19:0]       side_sq;
  logic signed [20:0] ext;
  logic signed [16:0] bound;
  logic [AW-1:0]     clr_r;
  logic [9:0]        col_r, row_r;
  logic [AW-1:0]     addr_r;
  logic signed [15:0] h_r;
  logic signed [15:0] hmin_r, hmax_r;
  logic [24:0]       out_r;
  logic [23:0]       div_a;
  logic [16:0]       div_b;
  logic              div_done;
  logic [23:0]       quot;
  logic signed [16:0] sq;
  logic signed [16:0] sq_fix;
  logic signed [15:0] cur_d;
  logic signed [16:0] diff;
  logic signed [16:0] sh;
  logic signed [15:0] nv;
  logic [16:0]       den, num;
  logic [6:0]        lvl;
  logic              rd_ok_r;

  logic signed [15:0] mem [CELLS];

  assign half = (int'(half_cells) > HALF_LIM) ? 9'(HALF_LIM) : half_cells;
  assign side = {half, 1'b0};
  assign side_sq = 20'(side * side);
  assign ext = 21'(half * cell_len);
  assign bound = {3'b0, z_bound};

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_beat[0];
      x_r <= in_beat[16:1]; y_r <= in_beat[32:17]; z_r <= in_beat[48:33];
      idx_in_r <= in_beat[66:49];
    end
  end

  // divider operands: |value| by cell length for binning, (h-min)*100 by (max-min) for level; floor fixup later
  logic signed [15:0] dsel;
  logic [16:0] dmag;
  assign dsel = cmd.div_sel ? y_r : x_r;
  assign dmag = dsel[15] ? 17'(-{dsel[15], dsel}) : {1'b0, dsel};
  assign num = 17'({h_r[15], h_r} - {hmin_r[15], hmin_r});
  assign den = 17'({hmax_r[15], hmax_r} - {hmin_r[15], hmin_r});
  assign div_a = cmd.sel_lvl ? 24'(num * 7'd100) : {7'd0, dmag};
  assign div_b = cmd.sel_lvl ? den : {7'd0, cell_len};

  hgeb_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(div_a),
    .divisor(div_b), .done(div_done), .quot(quot)
  );

  // floor of signed quotient: negative with remainder rounds down
  logic signed [16:0] qs;
  logic [33:0] back;
  assign qs = 17'(quot);
  assign back = 34'(quot[16:0] * cell_len);
  assign sq = dsel[15] ? -qs : qs;
  assign sq_fix = (dsel[15] && back[16:0] != dmag) ? sq - 17'sd1 : sq;

  logic signed [17:0] cellv;
  assign cellv = 18'(sq_fix) + 18'($signed({9'd0, half}));

  always_ff @(posedge clk) begin
    if (cmd.col_save) col_r <= cellv[9:0];
    if (cmd.row_save) row_r <= cellv[9:0];
  end
  logic col_ok_r, col_ok_w;
  assign col_ok_w = !cellv[17] && (cellv < 18'($signed({8'd0, side})));
  always_ff @(posedge clk) begin
    if (cmd.col_save) col_ok_r <= col_ok_w;
  end

  // memory address
  logic [AW-1:0] addr_w;
  assign addr_w = cmd_r ? AW'(idx_in_r) : AW'(20'(row_r * side) + 20'(col_r));

  // grid store with registered read
  logic        we;
  logic [AW-1:0] wa;
  logic signed [15:0] wd;
  assign we = cmd.mem_wr | cmd.clr_step;
  assign wa = cmd.clr_step ? clr_r : addr_r;
  assign wd = cmd.clr_step ? 16'sd0 : nv;
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (cmd.mem_rd) begin
      cur_d <= mem[addr_w];
      addr_r <= addr_w;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clr_step) clr_r <= clr_r + AW'(1);
  end

  // EMA: arithmetic shift is floor shift
  assign diff = {z_r[15], z_r} - {cur_d[15], cur_d};
  assign sh = diff >>> alpha_shift;
  assign nv = 16'(cur_d + sh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hmin_r <= 16'sh7fff; hmax_r <= 16'sh8000;
    end else if (cmd.mem_wr) begin
      if (nv < hmin_r) hmin_r <= nv;
      if (nv > hmax_r) hmax_r <= nv;
    end
  end

  // read result height is held in h_r once the memory word returns
  always_ff @(posedge clk) begin
    if (cmd.mem_wr || cmd.out_load) h_r <= h_r;
    else h_r <= cur_d;
  end

  assign lvl = (quot > 24'd100) ? 7'd100 : quot[6:0];
  logic idx_ok_w;
  assign idx_ok_w = ({2'b0, idx_in_r} < side_sq) && (32'(idx_in_r) < 32'(CELLS));
  always_ff @(posedge clk) rd_ok_r <= idx_ok_w;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (!rd_ok_r) out_r <= {ST_RANGE, 16'd0, 7'd0};
      else if (!(hmax_r > hmin_r)) out_r <= {ST_EMPTY, h_r, 7'd0};
      else if (!(h_r > hmin_r)) out_r <= {ST_OK, h_r, 7'd0};
      else out_r <= {ST_OK, h_r, lvl};
    end
  end
  assign out_beat = out_r;

  always_comb begin
    sts = '0;
    sts.div_done = div_done;
    sts.is_read = cmd_r;
    sts.pt_ok = (x_r < ext) && (x_r > -ext) && (y_r < ext) && (y_r > -ext) &&
                (z_r < bound) && (z_r > -bound);
    sts.cell_ok = col_ok_r && col_ok_w;
    sts.idx_ok = rd_ok_r;
    sts.range_ok = hmax_r > hmin_r;
    sts.num_pos = h_r > hmin_r;
    sts.clr_last = clr_r == AW'(CELLS - 1);
  end
  logic unused;
  assign unused = ^{back[33:17], quot[23:17]};
endmodule

// ===== design/hgeb_ctrl.sv =====
// ----------------------------------------------------------------------------
// hgeb_ctrl
// Sequencer: clearing pass, binning divides, EMA write, read and level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hgeb_ctrl import hgeb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output hgeb_cmd_t cmd,
  input  hgeb_sts_t sts
);
  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_CHK = 4'd2, S_DX = 4'd3,
    S_WX = 4'd4, S_DY = 4'd5, S_WY = 4'd6, S_RD = 4'd7, S_UPD = 4'd8,
    S_RRD = 4'd9, S_RH = 4'd10, S_DL = 4'd11, S_WL = 4'd12, S_OUT = 4'd13;

  logic [3:0] st_r, st_nxt;
  logic       ov_r, ov_nxt;

  assign in_ready = (st_r == S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    st_nxt = st_r; ov_nxt = ov_r; cmd = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (st_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) st_nxt = S_IDLE;
      end
      S_IDLE: if (in_valid && in_ready) begin
        cmd.load = 1'b1; st_nxt = S_CHK;
      end
      S_CHK: if (sts.is_read) begin
        st_nxt = S_RRD;
      end else if (sts.pt_ok) begin
        cmd.div_start = 1'b1; st_nxt = S_DX;
      end else st_nxt = S_IDLE;
      S_DX: if (sts.div_done) begin
        cmd.col_save = 1'b1; st_nxt = S_WX;
      end
      S_WX: begin
        cmd.div_sel = 1'b1; cmd.div_start = 1'b1; st_nxt = S_DY;
      end
      S_DY: begin
        cmd.div_sel = 1'b1;
        if (sts.div_done) begin
          cmd.row_save = 1'b1; st_nxt = S_WY;
        end
      end
      S_WY: begin
        cmd.div_sel = 1'b1;
        if (sts.cell_ok) begin
          cmd.mem_rd = 1'b1; st_nxt = S_RD;
        end else st_nxt = S_IDLE;
      end
      S_RD: st_nxt = S_UPD;
      S_UPD: begin
        cmd.mem_wr = 1'b1; st_nxt = S_IDLE;
      end
      S_RRD: begin
        cmd.mem_rd = 1'b1; st_nxt = S_RH;
      end
      S_RH: st_nxt = S_DL;
      S_DL: begin
        cmd.sel_lvl = 1'b1;
        if (sts.idx_ok && sts.range_ok && sts.num_pos) begin
          cmd.div_start = 1'b1; st_nxt = S_WL;
        end else st_nxt = S_OUT;
      end
      S_WL: begin
        cmd.sel_lvl = 1'b1;
        if (sts.div_done) st_nxt = S_OUT;
      end
      // wait here while the previous result is still held
      S_OUT: begin
        if (!ov_r || out_ready) begin
          cmd.out_load = 1'b1; ov_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt;
    end
  end

  `ASSERT_NEVER(a_wr_rd, clk, rst_n, cmd.mem_wr && cmd.mem_rd)
  `ASSERT_CLK(a_hold, clk, rst_n, (ov_r && !out_ready) |=> ov_r)
  `ASSERT_NEVER(a_acc_clr, clk, rst_n, in_ready && st_r == S_CLR)
endmodule

// ===== design/height_grid_ema_binner.sv =====
// ----------------------------------------------------------------------------
// height_grid_ema_binner
// Grid height map with EMA per cell, running min/max and level read-out.
// ----------------------------------------------------------------------------
// channel | dir | handshake            | payload
// in      | in  | in_tvalid/in_tready  | tdata cmd,x,y,z,cell_index
// out     | out | out_tvalid/out_tready| tdata level,height_mm,status
// cfg     | in  | APB psel/penable     | 4 registers at 4*i
// Add point: two 24-step serial divides, then the EMA write; an ignored point ends early.
// Read: grid word read, with the level divide only when the result has a level.
// After reset a clearing pass zeroes all GRID_SIDE*GRID_SIDE cells first.
// A result waits in the output register while the next beat is processed; the
// next result stalls the sequencer until the register is free.
`timescale 1ns / 1ps
module height_grid_ema_binner import hgeb_pkg::*; #(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd[0], x_mm[16:1], y_mm[32:17], z_mm[48:33], cell_index[66:49]
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // level[6:0], height_mm[22:7], status[24:23]
  output logic [31:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [9:0]  cs_r;
  logic [8:0]  hc_r;
  logic [13:0] zb_r;
  logic [3:0]  as_r;
  hgeb_cmd_t   cmd;
  hgeb_sts_t   sts;
  logic [24:0] ob;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r <= 10'd100; hc_r <= 9'd150; zb_r <= 14'd5000; as_r <= 4'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr)
        ADDR_CELL_LEN: cs_r <= cfg_pwdata[9:0];
        ADDR_HALF:     hc_r <= cfg_pwdata[8:0];
        ADDR_Z_BOUND:  zb_r <= cfg_pwdata[13:0];
        ADDR_ALPHA:    as_r <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (cfg_paddr)
      ADDR_CELL_LEN: cfg_prdata = {22'd0, cs_r};
      ADDR_HALF:     cfg_prdata = {23'd0, hc_r};
      ADDR_Z_BOUND:  cfg_prdata = {18'd0, zb_r};
      ADDR_ALPHA:    cfg_prdata = {28'd0, as_r};
      default: cfg_prdata = '0;
    endcase
  end

  hgeb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready), .cmd(cmd), .sts(sts)
  );

  hgeb_datapath #(.GRID_SIDE(GRID_SIDE)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_beat(in_tdata[66:0]),
    .cell_len(cs_r), .half_cells(hc_r), .z_bound(zb_r), .alpha_shift(as_r),
    .out_beat(ob)
  );
  assign out_tdata = {7'd0, ob};
  logic unused;
  assign unused = ^in_tdata[71:67];
endmodule
